>>> design/rsh_pkg.sv
// ----------------------------------------------------------------------------
// rsh_pkg
// Shared constants for the ray versus sphere hit test.
// ----------------------------------------------------------------------------
`default_nettype none

package rsh_pkg;

  localparam int COORD_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS_DEFAULT   = 16;
  localparam int RADIUS_WIDTH        = 24;
  localparam int DELTA_WIDTH         = 16;
  localparam int QUEUE_DEPTH         = 4;
  localparam int CFG_INDEX_WIDTH     = 3;

  localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 24'd65536;
  localparam logic [DELTA_WIDTH-1:0]  DELTA_RESET  = 16'd16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELTA    = 3'd4;

endpackage

`default_nettype wire

>>> design/rsh_front.sv
// ----------------------------------------------------------------------------
// rsh_front
// Front pipeline: offsets from the centre, dot products, snapped B and C.
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_front #(
  parameter int CW  = rsh_pkg::COORD_WIDTH_DEFAULT,
  parameter int F   = rsh_pkg::FRAC_BITS_DEFAULT,
  parameter int BW  = 2,
  parameter int CCW = 2
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              en,
  input  wire                              in_valid,
  input  wire  signed [CW-1:0]             start_x,
  input  wire  signed [CW-1:0]             start_y,
  input  wire  signed [CW-1:0]             start_z,
  input  wire  signed [F+1:0]              dir_x,
  input  wire  signed [F+1:0]              dir_y,
  input  wire  signed [F+1:0]              dir_z,
  input  wire  signed [CW-1:0]             center_x,
  input  wire  signed [CW-1:0]             center_y,
  input  wire  signed [CW-1:0]             center_z,
  input  wire  [rsh_pkg::RADIUS_WIDTH-1:0] radius,
  input  wire  [rsh_pkg::DELTA_WIDTH-1:0]  near_zero_delta,
  output logic                             out_valid,
  output logic signed [BW-1:0]             out_b,
  output logic signed [CCW-1:0]            out_c
);

  localparam int DW  = F + 2;
  localparam int EW  = CW + 1;
  localparam int PW  = DW + EW;
  localparam int RW  = rsh_pkg::RADIUS_WIDTH;
  localparam int DLW = rsh_pkg::DELTA_WIDTH + F;
  localparam int SW  = ((BW > CCW) ? BW : CCW) + DLW + 2;

  logic v1, v2, v3;
  logic signed [EW-1:0] ex, ey, ez;
  logic signed [DW-1:0] dx, dy, dz;
  logic signed [PW-1:0] px, py, pz;
  logic signed [2*EW-1:0] qx, qy, qz;
  logic [2*RW-1:0] rr;
  logic signed [BW-1:0] b_raw;
  logic signed [CCW-1:0] c_raw;
  logic signed [BW-1:0] b_sum;
  logic signed [CCW-1:0] c_sum;
  logic signed [SW-1:0] tol_p, tol_n, b_w, c_w;

  always_comb begin
    b_sum = BW'(px) + BW'(py) + BW'(pz);
    c_sum = CCW'(qx) + CCW'(qy) + CCW'(qz) - $signed(CCW'(rr));
    tol_p = $signed(SW'({near_zero_delta, {F{1'b0}}}));
    tol_n = -tol_p;
    b_w   = SW'(b_raw);
    c_w   = SW'(c_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex <= EW'(start_x) - EW'(center_x);
      ey <= EW'(start_y) - EW'(center_y);
      ez <= EW'(start_z) - EW'(center_z);
      dx <= dir_x;
      dy <= dir_y;
      dz <= dir_z;
      px <= PW'(dx) * PW'(ex);
      py <= PW'(dy) * PW'(ey);
      pz <= PW'(dz) * PW'(ez);
      qx <= (2*EW)'(ex) * (2*EW)'(ex);
      qy <= (2*EW)'(ey) * (2*EW)'(ey);
      qz <= (2*EW)'(ez) * (2*EW)'(ez);
      rr <= (2*RW)'(radius) * (2*RW)'(radius);
      b_raw <= b_sum <<< 1;
      c_raw <= c_sum;
      out_b <= (b_w < tol_p && b_w > tol_n) ? '0 : b_raw;
      out_c <= (c_w < tol_p && c_w > tol_n) ? '0 : c_raw;
    end
  end

endmodule

`default_nettype wire

>>> design/rsh_queue.sv
// ----------------------------------------------------------------------------
// rsh_queue
// Short request queue between the front and back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rsh_pkg::QUEUE_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire  [WIDTH-1:0] din,
  output logic             full,
  output logic             pop,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [NW-1:0] count;
  logic do_push;

  always_comb begin
    full    = (count == NW'(DEPTH));
    pop     = (count != '0);
    do_push = push && !full;
    dout    = mem[rp];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + NW'(do_push) - NW'(pop);
    end
  end

endmodule

`default_nettype wire

>>> design/rsh_back.sv
// ----------------------------------------------------------------------------
// rsh_back
// Back pipeline: discriminant and root test in split multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_back #(
  parameter int F   = rsh_pkg::FRAC_BITS_DEFAULT,
  parameter int BW  = 2,
  parameter int CCW = 2
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  input  wire  signed [BW-1:0]            b,
  input  wire  signed [CCW-1:0]           c,
  input  wire  [rsh_pkg::DELTA_WIDTH-1:0] near_zero_delta,
  output logic                            done,
  output logic                            hit
);

  localparam int DLW  = rsh_pkg::DELTA_WIDTH + F;
  localparam int KW   = ((BW > DLW + 2) ? BW : DLW + 2) + 1;
  localparam int H    = (KW + 1) / 2;
  localparam int CSW  = CCW + 2 + 2 * F;
  localparam int DSW  = ((4 * H > CSW) ? 4 * H : CSW) + 2;

  logic v1, v2, v3;
  logic [DLW:0] tol_t;
  logic signed [KW-1:0] k;
  logic [2*H-1:0] bmag, kmag;
  logic signed [CSW-1:0] cs1, cs2;
  logic kpos1, kpos2;
  logic [2*H-1:0] bll, blh, bhh, kll, klh, khh;
  logic signed [DSW-1:0] disc;
  logic [4*H-1:0] kk;
  logic kpos3;

  always_comb begin
    tol_t = {1'b0, near_zero_delta, {F{1'b0}}};
    if (near_zero_delta == '0) begin
      tol_t = (DLW + 1)'(1);
    end
    k = (KW'(tol_t) <<< 1) + KW'(b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    bmag  <= (b < 0) ? (2*H)'(-(KW'(b))) : (2*H)'(KW'(b));
    kmag  <= (2*H)'(k);
    kpos1 <= (k > 0);
    cs1   <= CSW'(c) <<< (2 + 2 * F);
    bll   <= (2*H)'(bmag[H-1:0]) * (2*H)'(bmag[H-1:0]);
    blh   <= (2*H)'(bmag[H-1:0]) * (2*H)'(bmag[2*H-1:H]);
    bhh   <= (2*H)'(bmag[2*H-1:H]) * (2*H)'(bmag[2*H-1:H]);
    kll   <= (2*H)'(kmag[H-1:0]) * (2*H)'(kmag[H-1:0]);
    klh   <= (2*H)'(kmag[H-1:0]) * (2*H)'(kmag[2*H-1:H]);
    khh   <= (2*H)'(kmag[2*H-1:H]) * (2*H)'(kmag[2*H-1:H]);
    kpos2 <= kpos1;
    cs2   <= cs1;
    disc  <= $signed(DSW'(((4*H)'(bhh) << (2 * H)) + ((4*H)'(blh) << (H + 1))
             + (4*H)'(bll))) - DSW'(cs2);
    kk    <= ((4*H)'(khh) << (2 * H)) + ((4*H)'(klh) << (H + 1)) + (4*H)'(kll);
    kpos3 <= kpos2;
    hit   <= (disc >= 0) && (!kpos3 || disc >= $signed(DSW'(kk)));
  end

endmodule

`default_nettype wire

>>> design/ray_sphere_hit_test_core.sv
// ----------------------------------------------------------------------------
// ray_sphere_hit_test_core
// Ray versus sphere hit test, one ray per clock while busy is low.
// ----------------------------------------------------------------------------
// A ray is taken when start is high and busy is low; one ray per clock is
// sustained while busy is low. The hit bit appears with a one-cycle done
// strobe after the ray is taken: four front stages form B and C, the queue
// holds them, four back stages compare the discriminant against the squared
// root bound. busy rises only when the queue between the two halves is full.
// Write the sphere registers only while no ray is in flight.
`default_nettype none

module ray_sphere_hit_test_core #(
  parameter int COORD_WIDTH = rsh_pkg::COORD_WIDTH_DEFAULT,
  parameter int FRAC_BITS   = rsh_pkg::FRAC_BITS_DEFAULT
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire  signed [COORD_WIDTH-1:0]       start_x,
  input  wire  signed [COORD_WIDTH-1:0]       start_y,
  input  wire  signed [COORD_WIDTH-1:0]       start_z,
  input  wire  signed [FRAC_BITS+1:0]         dir_x,
  input  wire  signed [FRAC_BITS+1:0]         dir_y,
  input  wire  signed [FRAC_BITS+1:0]         dir_z,
  input  wire                                 cfg_we,
  input  wire  [rsh_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [((COORD_WIDTH > rsh_pkg::RADIUS_WIDTH) ? COORD_WIDTH
                 : rsh_pkg::RADIUS_WIDTH)-1:0] cfg_data,
  output logic                                done,
  output logic                                hit
);

  localparam int RW  = rsh_pkg::RADIUS_WIDTH;
  localparam int EW  = COORD_WIDTH + 1;
  localparam int BW  = FRAC_BITS + 2 + EW + 3;
  localparam int CCW = ((2 * EW > 2 * RW) ? 2 * EW : 2 * RW) + 3;

  logic signed [COORD_WIDTH-1:0] center_x, center_y, center_z;
  logic [RW-1:0] radius;
  logic [rsh_pkg::DELTA_WIDTH-1:0] near_zero_delta;
  logic en, f_valid, q_full, q_pop;
  logic signed [BW-1:0] f_b, q_b;
  logic signed [CCW-1:0] f_c, q_c;
  logic [BW+CCW-1:0] q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius <= rsh_pkg::RADIUS_RESET;
      near_zero_delta <= rsh_pkg::DELTA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rsh_pkg::REG_CENTER_X: center_x <= cfg_data[COORD_WIDTH-1:0];
        rsh_pkg::REG_CENTER_Y: center_y <= cfg_data[COORD_WIDTH-1:0];
        rsh_pkg::REG_CENTER_Z: center_z <= cfg_data[COORD_WIDTH-1:0];
        rsh_pkg::REG_RADIUS:   radius <= cfg_data[RW-1:0];
        rsh_pkg::REG_DELTA:    near_zero_delta <= cfg_data[rsh_pkg::DELTA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en   = !(f_valid && q_full);
    busy = !en;
    q_b  = q_dout[BW+CCW-1:CCW];
    q_c  = q_dout[CCW-1:0];
  end

  rsh_front #(
    .CW (COORD_WIDTH),
    .F  (FRAC_BITS),
    .BW (BW),
    .CCW(CCW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (start),
    .start_x        (start_x),
    .start_y        (start_y),
    .start_z        (start_z),
    .dir_x          (dir_x),
    .dir_y          (dir_y),
    .dir_z          (dir_z),
    .center_x       (center_x),
    .center_y       (center_y),
    .center_z       (center_z),
    .radius         (radius),
    .near_zero_delta(near_zero_delta),
    .out_valid      (f_valid),
    .out_b          (f_b),
    .out_c          (f_c)
  );

  rsh_queue #(
    .WIDTH(BW + CCW),
    .DEPTH(rsh_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .push(f_valid),
    .din ({f_b, f_c}),
    .full(q_full),
    .pop (q_pop),
    .dout(q_dout)
  );

  rsh_back #(
    .F  (FRAC_BITS),
    .BW (BW),
    .CCW(CCW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (q_pop),
    .b              (q_b),
    .c              (q_c),
    .near_zero_delta(near_zero_delta),
    .done           (done),
    .hit            (hit)
  );

  a_done_follows_pop: assert property (@(posedge clk) disable iff (rst)
    $past(q_pop, 4) |-> done) else $error("request lost in back pipeline");

  a_done_has_pop: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(q_pop, 4)) else $error("result without request");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !busy) else $error("busy straight after reset");

endmodule

`default_nettype wire
